>>> src/tcs_pkg.sv
package tcs_pkg;

    // field widths of the command and result words
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int SCR_ROW_W  = 5;
    localparam int SCR_COL_W  = 7;
    localparam int WORD_W     = 16;
    localparam int CUR_COL_W  = 7;
    localparam int CUR_ROW_W  = 5;
    localparam int VIEW_W     = 9;
    localparam int COLOR_W    = 8;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // attribute after reset
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT         = 2'd0,
        CMD_SCROLL_UP   = 2'd1,
        CMD_SCROLL_DOWN = 2'd2,
        CMD_READ_CELL   = 2'd3
    } t_cmd;

endpackage

>>> src/tcs_in_if.sv
interface tcs_in_if;
    logic                           valid;
    logic                           ready;
    logic [tcs_pkg::CMD_W-1:0]      cmd;
    logic [tcs_pkg::CHAR_W-1:0]     char_code;
    logic [tcs_pkg::SCR_ROW_W-1:0]  screen_row;
    logic [tcs_pkg::SCR_COL_W-1:0]  screen_col;

    modport source (output valid, cmd, char_code, screen_row, screen_col, input ready);
    modport sink   (input valid, cmd, char_code, screen_row, screen_col, output ready);
endinterface

>>> src/tcs_out_if.sv
interface tcs_out_if;
    logic                           valid;
    logic                           ready;
    logic [tcs_pkg::WORD_W-1:0]     cell_word;
    logic [tcs_pkg::CUR_COL_W-1:0]  cursor_col;
    logic [tcs_pkg::CUR_ROW_W-1:0]  cursor_row;
    logic [tcs_pkg::VIEW_W-1:0]     view_top;
    logic                           following;

    modport source (output valid, cell_word, cursor_col, cursor_row, view_top, following,
                    input ready);
    modport sink   (input valid, cell_word, cursor_col, cursor_row, view_top, following,
                    output ready);
endinterface

>>> src/tcs_line_mem.sv
module tcs_line_mem #(
    parameter int HISTORY_DEPTH = 512,
    parameter int SCREEN_COLS   = 80
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0]   i_line,
    input  logic [$clog2(SCREEN_COLS)-1:0]     i_col,
    input  logic [tcs_pkg::CHAR_W-1:0]         i_wr_data,
    output logic [tcs_pkg::CHAR_W-1:0]         o_rd_data
);

    localparam int MEM_DEPTH = HISTORY_DEPTH * SCREEN_COLS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int LINE_W    = $clog2(HISTORY_DEPTH);
    localparam int COL_W     = $clog2(SCREEN_COLS);

    logic [tcs_pkg::CHAR_W-1:0] r_mem [MEM_DEPTH];
    logic [tcs_pkg::CHAR_W-1:0] r_rd_data;
    logic [AW-1:0]              addr;

    // line-major address: line * cols + col
    assign addr = AW'({{(AW-LINE_W){1'b0}}, i_line} * AW'(SCREEN_COLS))
                + AW'({{(AW-COL_W){1'b0}}, i_col});

    // single port, read-first, registered read data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/text_console_scrollback_core.sv
// a put writes its cell; a newline, or a put at a full line, first blanks the next ring line;
//   a backspace at a line start scans back over the trailing spaces of the previous line;
//   every command waits in S_DONE while the output register is held
// throughput: one word at a time, next word taken the cycle after the result is loaded
// reset (synchronous, active low): state registers cleared, then a clearing sweep writes spaces
//   to all HISTORY_DEPTH*SCREEN_COLS cells (40960 at defaults) while ready is low
module text_console_scrollback_core #(
    parameter int HISTORY_DEPTH = 512,
    parameter int SCREEN_COLS   = 80,
    parameter int SCREEN_ROWS   = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tcs_in_if.sink                       i_in,
    tcs_out_if.source                    o_out,
    input  logic                         i_cfg_wr_en,
    input  logic [tcs_pkg::COLOR_W-1:0]  i_cfg_wr_data
);

    localparam int LINE_W = $clog2(HISTORY_DEPTH);
    localparam int LU_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int CUR_W  = $clog2(SCREEN_COLS + 1);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int CW     = LINE_W + 1;

    localparam logic [LU_W-1:0]   DEPTH_LU  = LU_W'(HISTORY_DEPTH);
    localparam logic [LU_W-1:0]   ROWS_LU   = LU_W'(SCREEN_ROWS);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(HISTORY_DEPTH - 1);
    localparam logic [LINE_W-1:0] ROWS_M1   = LINE_W'(SCREEN_ROWS - 1);
    localparam logic [LINE_W-1:0] WRAP_ADD  = LINE_W'(HISTORY_DEPTH - SCREEN_ROWS + 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLS - 1);
    localparam logic [CUR_W-1:0]  COLS_CUR  = CUR_W'(SCREEN_COLS);
    localparam logic [CW-1:0]     DEPTH_CW  = CW'(HISTORY_DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_NEWLINE,
        S_CLR_LINE,
        S_PUT,
        S_WR_SPACE,
        S_BS_RD,
        S_BS_CHK,
        S_FIN,
        S_VIEW,
        S_RD_ADDR,
        S_RD_MEM,
        S_RD_WAIT,
        S_DONE
    } t_state;

    t_state                          r_state;
    tcs_pkg::t_cmd                   r_cmd;
    logic [tcs_pkg::CHAR_W-1:0]      r_ch;
    logic [tcs_pkg::SCR_ROW_W-1:0]   r_row;
    logic [tcs_pkg::SCR_COL_W-1:0]   r_col;
    logic [LINE_W-1:0]               r_wline;
    logic [CUR_W-1:0]                r_wcol;
    logic [LU_W-1:0]                 r_lines;
    logic [LINE_W-1:0]               r_sb;
    logic [LINE_W-1:0]               r_top;
    logic                            r_follow;
    logic [CUR_W-1:0]                r_cx;
    logic [ROW_W-1:0]                r_cy;
    logic [tcs_pkg::COLOR_W-1:0]     r_color;
    logic [COL_W-1:0]                r_idx;
    logic [LINE_W-1:0]               r_mline;
    logic                            r_pend;
    logic [tcs_pkg::WORD_W-1:0]      r_word;

    logic                            r_ovalid;
    logic [tcs_pkg::WORD_W-1:0]      r_o_word;
    logic [tcs_pkg::CUR_COL_W-1:0]   r_o_cx;
    logic [tcs_pkg::CUR_ROW_W-1:0]   r_o_cy;
    logic [tcs_pkg::VIEW_W-1:0]      r_o_top;
    logic                            r_o_follow;

    logic                            mem_we;
    logic [LINE_W-1:0]               mem_line;
    logic [COL_W-1:0]                mem_col;
    logic [tcs_pkg::CHAR_W-1:0]      mem_wdata;
    logic [tcs_pkg::CHAR_W-1:0]      mem_rdata;

    logic [LINE_W-1:0]               bot;
    logic [LU_W-1:0]                 ms;
    logic [LINE_W-1:0]               wline_inc;
    logic [LINE_W-1:0]               wline_dec;
    logic [CUR_W-1:0]                wcol_m1;
    logic [LU_W-1:0]                 sb_lu;
    logic [LU_W-1:0]                 sb_clamp;
    logic [CW-1:0]                   wrap_diff;
    logic [CW-1:0]                   cand;
    logic [CW-1:0]                   lines_cw;
    logic                            full;
    logic [CUR_W+tcs_pkg::CUR_COL_W-1:0] cx_ext;
    logic [ROW_W+tcs_pkg::CUR_ROW_W-1:0] cy_ext;
    logic [LINE_W+tcs_pkg::VIEW_W-1:0]   top_ext;

    // line store with its address unit
    tcs_line_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SCREEN_COLS   (SCREEN_COLS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_line    (mem_line),
        .i_col     (mem_col),
        .i_wr_data (mem_wdata),
        .o_rd_data (mem_rdata)
    );

    // ring pointer steps
    assign wline_inc = (r_wline == LINE_LAST) ? '0 : r_wline + LINE_W'(1);
    assign wline_dec = (r_wline == '0) ? LINE_LAST : r_wline - LINE_W'(1);
    assign wcol_m1   = r_wcol - CUR_W'(1);
    assign full      = (r_lines >= DEPTH_LU);

    // bottom-of-view top line and scroll limit
    always_comb begin
        if (r_lines <= ROWS_LU) begin
            bot = '0;
        end else if (!full) begin
            bot = LINE_W'(r_lines - ROWS_LU);
        end else if (r_wline >= ROWS_M1) begin
            bot = r_wline - ROWS_M1;
        end else begin
            bot = r_wline + WRAP_ADD;
        end
        ms = (r_lines > ROWS_LU) ? (r_lines - ROWS_LU) : '0;
    end

    // view placement terms
    assign sb_lu     = LU_W'(r_sb);
    assign sb_clamp  = (sb_lu > ms) ? ms : sb_lu;
    assign wrap_diff = {1'b0, bot} + DEPTH_CW - {1'b0, r_sb};

    // read position in the ring
    assign cand     = {1'b0, r_top} + CW'(r_row);
    assign lines_cw = CW'(r_lines);

    // line store port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_line  = r_wline;
        mem_col   = r_wcol[COL_W-1:0];
        mem_wdata = tcs_pkg::CH_SPACE;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_line = r_mline;
                mem_col  = r_idx;
            end
            S_CLR_LINE: begin
                mem_we  = 1'b1;
                mem_col = r_idx;
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_wdata = r_ch;
            end
            S_WR_SPACE: begin
                mem_we = 1'b1;
            end
            S_BS_RD: begin
                mem_col = wcol_m1[COL_W-1:0];
            end
            S_RD_MEM: begin
                mem_line = r_mline;
                mem_col  = r_col[COL_W-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tcs_pkg::COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_color <= i_cfg_wr_data;
        end
    end

    // output widths
    assign cx_ext  = {{tcs_pkg::CUR_COL_W{1'b0}}, r_cx};
    assign cy_ext  = {{tcs_pkg::CUR_ROW_W{1'b0}}, r_cy};
    assign top_ext = {{tcs_pkg::VIEW_W{1'b0}}, r_top};

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_wline  <= '0;
            r_wcol   <= '0;
            r_lines  <= LU_W'(1);
            r_sb     <= '0;
            r_top    <= '0;
            r_follow <= 1'b1;
            r_cx     <= '0;
            r_cy     <= '0;
            r_idx    <= '0;
            r_mline  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // the handoff step below reloads the output register itself
            if (o_out.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                // reset sweep, one cell a cycle
                S_CLEAR: begin
                    if (r_idx == COL_LAST) begin
                        r_idx <= '0;
                        if (r_mline == LINE_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_mline <= r_mline + LINE_W'(1);
                        end
                    end else begin
                        r_idx <= r_idx + COL_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd   <= tcs_pkg::t_cmd'(i_in.cmd);
                        r_ch    <= i_in.char_code;
                        r_row   <= i_in.screen_row;
                        r_col   <= i_in.screen_col;
                        r_word  <= '0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (r_cmd)
                        tcs_pkg::CMD_PUT: begin
                            if (r_ch == tcs_pkg::CH_BACKSPACE) begin
                                if (r_wcol != '0) begin
                                    r_wcol  <= wcol_m1;
                                    r_state <= S_WR_SPACE;
                                end else if (r_lines > LU_W'(1)) begin
                                    r_wline <= wline_dec;
                                    r_wcol  <= COLS_CUR;
                                    r_state <= S_BS_RD;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end else if (r_ch == tcs_pkg::CH_NEWLINE) begin
                                r_pend  <= 1'b0;
                                r_state <= S_NEWLINE;
                            end else if (r_wcol >= COLS_CUR) begin
                                r_pend  <= 1'b1;
                                r_state <= S_NEWLINE;
                            end else begin
                                r_state <= S_PUT;
                            end
                        end
                        tcs_pkg::CMD_SCROLL_UP: begin
                            // a successful step up always leaves the bottom
                            if (ms != '0) begin
                                if (sb_lu < ms) begin
                                    r_sb <= r_sb + LINE_W'(1);
                                end
                                r_follow <= 1'b0;
                                r_state  <= S_VIEW;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        tcs_pkg::CMD_SCROLL_DOWN: begin
                            if (r_sb != '0) begin
                                r_sb <= r_sb - LINE_W'(1);
                            end
                            r_follow <= (r_sb < LINE_W'(2));
                            r_state  <= S_VIEW;
                        end
                        tcs_pkg::CMD_READ_CELL: begin
                            r_state <= S_RD_ADDR;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                // advance the ring, then blank the new line
                S_NEWLINE: begin
                    r_wcol  <= '0;
                    r_wline <= wline_inc;
                    if (!full) begin
                        r_lines <= r_lines + LU_W'(1);
                    end
                    r_idx   <= '0;
                    r_state <= S_CLR_LINE;
                end
                S_CLR_LINE: begin
                    if (r_idx == COL_LAST) begin
                        r_idx   <= '0;
                        r_state <= r_pend ? S_PUT : S_FIN;
                    end else begin
                        r_idx <= r_idx + COL_W'(1);
                    end
                end
                S_PUT: begin
                    r_wcol  <= r_wcol + CUR_W'(1);
                    r_state <= S_FIN;
                end
                S_WR_SPACE: begin
                    r_state <= S_FIN;
                end
                // scan back over trailing spaces of the previous line
                S_BS_RD: begin
                    r_state <= S_BS_CHK;
                end
                S_BS_CHK: begin
                    r_wcol <= wcol_m1;
                    if (mem_rdata != tcs_pkg::CH_SPACE) begin
                        r_state <= S_WR_SPACE;
                    end else if (r_wcol == CUR_W'(1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_BS_RD;
                    end
                end
                // cursor and followed view after a put
                S_FIN: begin
                    r_cx <= r_wcol;
                    if (r_lines < ROWS_LU) begin
                        r_cy <= ROW_W'(r_lines - LU_W'(1));
                    end else begin
                        r_cy <= ROW_W'(SCREEN_ROWS - 1);
                    end
                    if (r_follow) begin
                        r_top <= bot;
                    end
                    r_state <= S_DONE;
                end
                // view after a scroll step
                S_VIEW: begin
                    if (!full) begin
                        r_sb  <= LINE_W'(sb_clamp);
                        r_top <= bot - LINE_W'(sb_clamp);
                    end else if (wrap_diff >= DEPTH_CW) begin
                        r_top <= LINE_W'(wrap_diff - DEPTH_CW);
                    end else begin
                        r_top <= LINE_W'(wrap_diff);
                    end
                    r_state <= S_DONE;
                end
                // screen position to ring line
                S_RD_ADDR: begin
                    if (r_row >= tcs_pkg::SCR_ROW_W'(SCREEN_ROWS)
                            || {1'b0, r_col} >= (tcs_pkg::SCR_COL_W + 1)'(SCREEN_COLS)) begin
                        r_word  <= '0;
                        r_state <= S_DONE;
                    end else if (!full) begin
                        if (cand < lines_cw) begin
                            r_mline <= LINE_W'(cand);
                            r_state <= S_RD_MEM;
                        end else begin
                            r_word  <= {r_color, tcs_pkg::CH_SPACE};
                            r_state <= S_DONE;
                        end
                    end else begin
                        if (cand >= DEPTH_CW) begin
                            r_mline <= LINE_W'(cand - DEPTH_CW);
                        end else begin
                            r_mline <= LINE_W'(cand);
                        end
                        r_state <= S_RD_MEM;
                    end
                end
                S_RD_MEM: begin
                    r_state <= S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    r_word  <= {r_color, mem_rdata};
                    r_state <= S_DONE;
                end
                // hand the word to the output register
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_word   <= r_word;
                        r_o_cx     <= cx_ext[tcs_pkg::CUR_COL_W-1:0];
                        r_o_cy     <= cy_ext[tcs_pkg::CUR_ROW_W-1:0];
                        r_o_top    <= top_ext[tcs_pkg::VIEW_W-1:0];
                        r_o_follow <= r_follow;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.cell_word = r_o_word;
    assign o_out.cursor_col = r_o_cx;
    assign o_out.cursor_row = r_o_cy;
    assign o_out.view_top  = r_o_top;
    assign o_out.following = r_o_follow;

    // write column stays within one line
    a_wcol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcol <= COLS_CUR)
        else $error("write column beyond line width");

    // line count stays between one and the ring depth
    a_lines_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lines != '0) && (r_lines <= DEPTH_LU))
        else $error("line count out of range");

    // scroll offset never passes the scrollable history between commands
    a_sb_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (sb_lu <= ms))
        else $error("scroll offset beyond history");

    // a result only appears from the handoff step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !$past(r_ovalid)) |-> $past(r_state == S_DONE))
        else $error("result word without completed command");

endmodule

>>> dv/text_console_scrollback_core_tb.sv
module text_console_scrollback_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST          = 512;
    localparam int COLS          = 80;
    localparam int ROWS          = 25;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 2 * COLS + 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_PRINTED   = 50;

    // one result word as seen on the output channel
    typedef struct packed {
        logic [tcs_pkg::WORD_W-1:0]    cell_word;
        logic [tcs_pkg::CUR_COL_W-1:0] cursor_col;
        logic [tcs_pkg::CUR_ROW_W-1:0] cursor_row;
        logic [tcs_pkg::VIEW_W-1:0]    view_top;
        logic                          following;
    } t_console_view;

    // console predictor and result scoreboard
    class t_console_scoreboard;
        logic [tcs_pkg::CHAR_W-1:0]    glyphs [HIST*COLS];
        logic [tcs_pkg::VIEW_W-1:0]    wr_line;
        logic [tcs_pkg::CUR_COL_W-1:0] wr_col;
        logic [9:0]                    used_lines;
        logic [tcs_pkg::VIEW_W-1:0]    back_lines;
        logic [tcs_pkg::VIEW_W-1:0]    top_line;
        bit                            tracking;
        logic [tcs_pkg::CUR_COL_W-1:0] cur_x;
        logic [tcs_pkg::CUR_ROW_W-1:0] cur_y;
        logic [tcs_pkg::COLOR_W-1:0]   text_attr;
        t_console_view                 pending_views[$];

        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_cmd[4];
        int unsigned n_wraps;
        int unsigned deepest_back;
        bit          ring_filled;

        function new();
            foreach (glyphs[i]) glyphs[i] = tcs_pkg::CH_SPACE;
            wr_line      = '0;
            wr_col       = '0;
            used_lines   = 10'd1;
            back_lines   = '0;
            top_line     = '0;
            tracking     = 1'b1;
            cur_x        = '0;
            cur_y        = '0;
            text_attr    = tcs_pkg::COLOR_RESET;
            errors       = 0;
            n_checked    = 0;
            n_wraps      = 0;
            deepest_back = 0;
            ring_filled  = 1'b0;
            foreach (n_cmd[i]) n_cmd[i] = 0;
        endfunction

        function int glyph_index(int hist_line, int col);
            return (hist_line % HIST) * COLS + (col % COLS);
        endfunction

        // history line shown at the top when the view sits at the bottom
        function int view_bottom();
            if (used_lines <= ROWS)
                return 0;
            if (used_lines < HIST)
                return int'(used_lines) - ROWS;
            return (int'(wr_line) + HIST - (ROWS - 1)) % HIST;
        endfunction

        function int scroll_limit();
            return (used_lines > ROWS) ? int'(used_lines) - ROWS : 0;
        endfunction

        // clamp the scrollback while the ring is not full and recompute the top of the view
        function void settle_view();
            int b;
            int m;
            b = view_bottom();
            m = scroll_limit();
            if (used_lines < HIST) begin
                if (back_lines > m)
                    back_lines = tcs_pkg::VIEW_W'(m);
                top_line = tcs_pkg::VIEW_W'(b - int'(back_lines));
            end else begin
                top_line = tcs_pkg::VIEW_W'((b + HIST - int'(back_lines) % HIST) % HIST);
            end
        endfunction

        // advance the ring and blank the new line
        function void open_line();
            wr_col  = '0;
            wr_line = tcs_pkg::VIEW_W'((int'(wr_line) + 1) % HIST);
            for (int x = 0; x < COLS; x++)
                glyphs[glyph_index(wr_line, x)] = tcs_pkg::CH_SPACE;
            if (used_lines < HIST)
                used_lines++;
            if (used_lines == HIST)
                ring_filled = 1'b1;
        endfunction

        function void put_char(logic [tcs_pkg::CHAR_W-1:0] ch);
            int col;
            if (ch == tcs_pkg::CH_BACKSPACE) begin
                if (wr_col > 0) begin
                    wr_col--;
                    glyphs[glyph_index(wr_line, wr_col)] = tcs_pkg::CH_SPACE;
                end else if (used_lines > 1) begin
                    // step back to the last non-space of the previous line
                    wr_line = tcs_pkg::VIEW_W'((int'(wr_line) + HIST - 1) % HIST);
                    col = COLS;
                    while (col > 0 &&
                           glyphs[glyph_index(wr_line, col - 1)] == tcs_pkg::CH_SPACE)
                        col--;
                    if (col > 0) begin
                        col--;
                        glyphs[glyph_index(wr_line, col)] = tcs_pkg::CH_SPACE;
                    end
                    wr_col = tcs_pkg::CUR_COL_W'(col);
                end
            end else if (ch == tcs_pkg::CH_NEWLINE) begin
                open_line();
            end else begin
                if (wr_col >= COLS) begin
                    open_line();
                    n_wraps++;
                end
                glyphs[glyph_index(wr_line, wr_col)] = ch;
                wr_col++;
            end
            cur_x = wr_col;
            cur_y = (used_lines < ROWS) ? tcs_pkg::CUR_ROW_W'(int'(used_lines) - 1)
                                        : tcs_pkg::CUR_ROW_W'(ROWS - 1);
            if (tracking)
                top_line = tcs_pkg::VIEW_W'(view_bottom());
        endfunction

        function logic [tcs_pkg::WORD_W-1:0] read_cell(
                logic [tcs_pkg::SCR_ROW_W-1:0] row,
                logic [tcs_pkg::SCR_COL_W-1:0] col);
            logic [tcs_pkg::CHAR_W-1:0] ch;
            int                         hist_line;
            ch = tcs_pkg::CH_SPACE;
            if (row >= ROWS || col >= COLS)
                return '0;
            hist_line = int'(top_line) + int'(row);
            // rows past the stored lines show blank until the ring fills
            if (used_lines >= HIST || hist_line < used_lines)
                ch = glyphs[glyph_index(hist_line, col)];
            return {text_attr, ch};
        endfunction

        // accepted input word: advance the model and queue the expected result
        function void note_word(tcs_pkg::t_cmd cmd, logic [tcs_pkg::CHAR_W-1:0] ch,
                                logic [tcs_pkg::SCR_ROW_W-1:0] row,
                                logic [tcs_pkg::SCR_COL_W-1:0] col);
            t_console_view v;
            int            m;
            v.cell_word = '0;
            case (cmd)
                tcs_pkg::CMD_PUT: begin
                    put_char(ch);
                end
                tcs_pkg::CMD_SCROLL_UP: begin
                    m = scroll_limit();
                    if (m != 0) begin
                        if (back_lines < m)
                            back_lines++;
                        tracking = (back_lines == 0);
                        settle_view();
                    end
                end
                tcs_pkg::CMD_SCROLL_DOWN: begin
                    if (back_lines > 0)
                        back_lines--;
                    tracking = (back_lines == 0);
                    settle_view();
                end
                default: begin
                    v.cell_word = read_cell(row, col);
                end
            endcase
            if (back_lines > deepest_back)
                deepest_back = back_lines;
            n_cmd[cmd]++;
            v.cursor_col = cur_x;
            v.cursor_row = cur_y;
            v.view_top   = top_line;
            v.following  = tracking;
            pending_views.push_back(v);
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] result %0d: %s", $time, n_checked, msg);
            errors++;
        endtask

        // compare one output word against the oldest expectation
        task check_word(t_console_view got);
            t_console_view want;
            if (pending_views.size() == 0) begin
                report_mismatch("output word with no expected result pending");
            end else begin
                want = pending_views.pop_front();
                if (got.cell_word !== want.cell_word)
                    report_mismatch($sformatf("cell_word got %h want %h",
                                              got.cell_word, want.cell_word));
                if (got.cursor_col !== want.cursor_col)
                    report_mismatch($sformatf("cursor_col got %0d want %0d",
                                              got.cursor_col, want.cursor_col));
                if (got.cursor_row !== want.cursor_row)
                    report_mismatch($sformatf("cursor_row got %0d want %0d",
                                              got.cursor_row, want.cursor_row));
                if (got.view_top !== want.view_top)
                    report_mismatch($sformatf("view_top got %0d want %0d",
                                              got.view_top, want.view_top));
                if (got.following !== want.following)
                    report_mismatch($sformatf("following got %b want %b",
                                              got.following, want.following));
            end
            n_checked++;
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [tcs_pkg::COLOR_W-1:0]   i_cfg_wr_data;

    tcs_in_if  in_if ();
    tcs_out_if out_if ();

    t_console_scoreboard sb;
    int unsigned         words_sent;
    bit                  tx_calm;
    bit                  rx_calm;
    bit                  rx_hold_req;

    text_console_scrollback_core #(
        .HISTORY_DEPTH (HIST),
        .SCREEN_COLS   (COLS),
        .SCREEN_ROWS   (ROWS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [tcs_pkg::SCR_ROW_W-1:0] pick_row();
        return ($urandom_range(0, 6) == 0)
            ? tcs_pkg::SCR_ROW_W'($urandom_range(ROWS, 31))
            : tcs_pkg::SCR_ROW_W'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic logic [tcs_pkg::SCR_COL_W-1:0] pick_col();
        return ($urandom_range(0, 6) == 0)
            ? tcs_pkg::SCR_COL_W'($urandom_range(COLS, 127))
            : tcs_pkg::SCR_COL_W'($urandom_range(0, COLS - 1));
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(tcs_pkg::t_cmd cmd, logic [tcs_pkg::CHAR_W-1:0] ch,
                             logic [tcs_pkg::SCR_ROW_W-1:0] row,
                             logic [tcs_pkg::SCR_COL_W-1:0] col);
        int gap;
        in_if.valid      <= 1'b1;
        in_if.cmd        <= cmd;
        in_if.char_code  <= ch;
        in_if.screen_row <= row;
        in_if.screen_col <= col;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1)
            @(posedge i_clk);
        sb.note_word(cmd, ch, row, col);
        words_sent++;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic put(logic [tcs_pkg::CHAR_W-1:0] ch);
        send_word(tcs_pkg::CMD_PUT, ch, tcs_pkg::SCR_ROW_W'($urandom),
                  tcs_pkg::SCR_COL_W'($urandom));
    endtask

    task automatic read_at(logic [tcs_pkg::SCR_ROW_W-1:0] row,
                           logic [tcs_pkg::SCR_COL_W-1:0] col);
        send_word(tcs_pkg::CMD_READ_CELL, tcs_pkg::CHAR_W'($urandom), row, col);
    endtask

    task automatic scroll(tcs_pkg::t_cmd cmd);
        send_word(cmd, tcs_pkg::CHAR_W'($urandom), tcs_pkg::SCR_ROW_W'($urandom),
                  tcs_pkg::SCR_COL_W'($urandom));
    endtask

    // move the view up then back down, peeking at the screen on the way
    task automatic scroll_burst(int ups, int downs);
        repeat (ups) begin
            scroll(tcs_pkg::CMD_SCROLL_UP);
            if ($urandom_range(0, 5) == 0)
                read_at(pick_row(), pick_col());
        end
        repeat (downs) begin
            scroll(tcs_pkg::CMD_SCROLL_DOWN);
            if ($urandom_range(0, 5) == 0)
                read_at(pick_row(), pick_col());
        end
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_views.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_color(logic [tcs_pkg::COLOR_W-1:0] c);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= c;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.text_attr = c;
    endtask

    // random console traffic built from typical sequences plus some noise
    task automatic run_traffic(int n_words, int nl_pct, int nl_max);
        int unsigned                stop;
        int                         kind;
        int                         len;
        logic [tcs_pkg::CHAR_W-1:0] c;
        stop = words_sent + n_words;
        while (words_sent < stop) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < nl_pct) begin
                len = $urandom_range(1, nl_max);
                repeat (len) put(tcs_pkg::CH_NEWLINE);
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 35) begin
                    // a line of text, sometimes running past the row width
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(COLS, 2 * COLS + 10)
                                                      : $urandom_range(0, COLS - 10);
                    repeat (len) begin
                        kind = $urandom_range(0, 99);
                        if (kind < 70)
                            c = tcs_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E));
                        else if (kind < 85)
                            c = tcs_pkg::CH_SPACE;
                        else
                            c = tcs_pkg::CHAR_W'($urandom);
                        if (c == tcs_pkg::CH_BACKSPACE || c == tcs_pkg::CH_NEWLINE)
                            c = tcs_pkg::CH_SPACE;
                        put(c);
                    end
                    if ($urandom_range(0, 3) != 0)
                        put(tcs_pkg::CH_NEWLINE);
                end else if (kind < 50) begin
                    // erase run, sometimes back across line starts
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(COLS, 3 * COLS)
                                                      : $urandom_range(1, 12);
                    repeat (len) put(tcs_pkg::CH_BACKSPACE);
                end else if (kind < 65) begin
                    scroll_burst($urandom_range(1, 30), $urandom_range(0, 35));
                end else if (kind < 85) begin
                    repeat ($urandom_range(1, 10)) read_at(pick_row(), pick_col());
                end else begin
                    repeat ($urandom_range(1, 8))
                        send_word(tcs_pkg::t_cmd'($urandom_range(0, 3)),
                                  tcs_pkg::CHAR_W'($urandom),
                                  tcs_pkg::SCR_ROW_W'($urandom),
                                  tcs_pkg::SCR_COL_W'($urandom));
                end
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int            stall_cnt;
        int unsigned   accepted;
        t_console_view got;
        stall_cnt    = 0;
        accepted     = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.cell_word  = out_if.cell_word;
                got.cursor_col = out_if.cursor_col;
                got.cursor_row = out_if.cursor_row;
                got.view_top   = out_if.view_top;
                got.following  = out_if.following;
                sb.check_word(got);
                accepted++;
                if (accepted % 97 == 0)
                    rx_calm = ($urandom_range(0, 3) == 0);
                if (rx_hold_req) begin
                    stall_cnt   = HOLD_CYCLES;
                    rx_hold_req = 1'b0;
                end else begin
                    stall_cnt = pick_gap(rx_calm);
                end
            end else if (stall_cnt == 0 && !rx_calm && $urandom_range(0, 29) == 0) begin
                stall_cnt = $urandom_range(1, 6);
            end
            if (stall_cnt > 0) begin
                out_if.ready <= 1'b0;
                stall_cnt--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        #(30_000_000);
        $display("** text_console_scrollback_core: FAILED **");
        $finish;
    end

    // stimulus
    initial begin
        sb               = new();
        words_sent       = 0;
        tx_calm          = 1'b0;
        rx_calm          = 1'b0;
        rx_hold_req      = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        in_if.valid      = 1'b0;
        in_if.cmd        = tcs_pkg::CMD_PUT;
        in_if.char_code  = '0;
        in_if.screen_row = '0;
        in_if.screen_col = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty screen, field extremes, edge cases of erase and scroll
        read_at(5'd0, 7'd0);
        read_at(5'd24, 7'd79);
        read_at(5'd25, 7'd0);
        read_at(5'd0, 7'd80);
        read_at(5'd31, 7'd127);
        put(8'h41);
        put(8'hFF);
        put(8'h00);
        put(tcs_pkg::CH_BACKSPACE);
        put(tcs_pkg::CH_BACKSPACE);
        put(tcs_pkg::CH_BACKSPACE);
        put(tcs_pkg::CH_BACKSPACE);
        scroll(tcs_pkg::CMD_SCROLL_UP);
        scroll(tcs_pkg::CMD_SCROLL_DOWN);
        put(tcs_pkg::CH_NEWLINE);
        put(tcs_pkg::CH_BACKSPACE);
        put(8'h7E);
        put(tcs_pkg::CH_NEWLINE);
        put(8'h31);
        put(tcs_pkg::CH_BACKSPACE);
        put(tcs_pkg::CH_BACKSPACE);
        read_at(5'd1, 7'd0);
        read_at(5'd0, 7'd0);
        drain();

        // dark attribute, mixed traffic
        write_color(8'h00);
        run_traffic(250, 10, 8);
        drain();

        // bright attribute, newline heavy so the ring fills and wraps
        write_color(8'hFF);
        run_traffic(550, 70, 60);
        drain();

        // full ring, one long output hold-off while words keep coming
        write_color(tcs_pkg::COLOR_W'($urandom_range(1, 254)));
        rx_hold_req = 1'b1;
        run_traffic(250, 40, 20);
        drain();

        // scroll to the top of the full history and partly back
        write_color(tcs_pkg::COLOR_W'($urandom));
        scroll_burst(HIST - ROWS + 13, 30);
        put(8'h5A);
        read_at(5'd0, 7'd0);
        drain();

        $display("run covered %0d words: %0d put, %0d scroll up, %0d scroll down, %0d read",
                 words_sent, sb.n_cmd[tcs_pkg::CMD_PUT], sb.n_cmd[tcs_pkg::CMD_SCROLL_UP],
                 sb.n_cmd[tcs_pkg::CMD_SCROLL_DOWN], sb.n_cmd[tcs_pkg::CMD_READ_CELL]);
        $display("ring %s, deepest scrollback %0d, %0d line wraps, %0d results, %0d mismatches",
                 sb.ring_filled ? "filled" : "not filled", sb.deepest_back, sb.n_wraps,
                 sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("** text_console_scrollback_core: PASSED **");
        end else begin
            $display("** text_console_scrollback_core: FAILED **");
        end
        $finish;
    end

endmodule
